>>> rtl/fpd_pkg.sv
// fpd_pkg: shared types, register indexes and reset defaults for the flight phase detector.
// No dependencies; imported by fpd_fuse, flight_phase_detector_top, fpd_phase_checker and tb_top.

package fpd_pkg;

	localparam int ALT_BITS_DEF   = 24;
	localparam int COUNT_BITS_DEF = 16;

	localparam int ALPHA_W = 17;
	localparam int RATE_W  = 16;
	localparam int DT_W    = 16;
	localparam int DIST_W  = 24;
	localparam int TICK_W  = 16;
	localparam int IDX_W   = 3;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_SEEK   = 2'd1,
		MODE_SPIRAL = 2'd2,
		MODE_GROUND = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ALPHA      = 3'd0,
		REG_APO_FLOOR  = 3'd1,
		REG_GND_CEIL   = 3'd2,
		REG_DESC_RATE  = 3'd3,
		REG_STILL_BAND = 3'd4,
		REG_APO_LIMIT  = 3'd5,
		REG_GND_LIMIT  = 3'd6,
		REG_SPIRAL_RAD = 3'd7
	} reg_idx_t;

	localparam logic [ALPHA_W-1:0] ALPHA_RST      = 17'd3277;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 17'h10000;
	localparam logic [RATE_W-1:0]  DESC_RATE_RST  = 16'd120;
	localparam logic [RATE_W-1:0]  STILL_BAND_RST = 16'd30;
	localparam logic [RATE_W-1:0]  APO_LIMIT_RST  = 16'd200;
	localparam logic [RATE_W-1:0]  GND_LIMIT_RST  = 16'd300;
	localparam logic [RATE_W-1:0]  SPIRAL_RAD_RST = 16'd10;

endpackage

>>> rtl/fpd_fuse.sv
// fpd_fuse: complementary fusion of barometric and GPS altitude with a Q1.16 weight.
// Depends on fpd_pkg. Pure combinational, one multiplier.

module fpd_fuse #(
	parameter int ALT_BITS = fpd_pkg::ALT_BITS_DEF
) (
	input  logic signed [ALT_BITS-1:0]         baro_alt_cm,
	input  logic                               baro_ok,
	input  logic signed [ALT_BITS-1:0]         gps_alt_cm,
	input  logic                               gps_ok,
	input  logic        [fpd_pkg::ALPHA_W-1:0] alpha_q16,
	output logic signed [ALT_BITS-1:0]         fused_alt_cm,
	output logic                               fused_ok
);
	import fpd_pkg::*;

	localparam int DIFF_W = ALT_BITS + 1;
	localparam int PROD_W = DIFF_W + ALPHA_W + 1;
	localparam int SUM_W  = ALT_BITS + 2;

	logic        [ALPHA_W-1:0] alpha_sat;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD_W-1:0]  prod;
	logic signed [SUM_W-1:0]   blend;

	// baro*a + gps*(1-a) == gps + (baro-gps)*a; gps term is exact so floor applies to the product
	assign alpha_sat = alpha_q16[ALPHA_W-1] ? ALPHA_ONE : alpha_q16;
	assign diff      = DIFF_W'(baro_alt_cm) - DIFF_W'(gps_alt_cm);
	assign prod      = PROD_W'(diff) * signed'({1'b0, alpha_sat});
	assign blend     = SUM_W'(gps_alt_cm) + SUM_W'(prod >>> 16);

	always_comb begin
		fused_alt_cm = '0;
		if (baro_ok && gps_ok) begin
			fused_alt_cm = blend[ALT_BITS-1:0];
		end else if (baro_ok) begin
			fused_alt_cm = baro_alt_cm;
		end else if (gps_ok) begin
			fused_alt_cm = gps_alt_cm;
		end
	end

	assign fused_ok = baro_ok | gps_ok;

endmodule

>>> rtl/flight_phase_detector_top.sv
// Flight phase detector: an accepted input beat passes the input register, the fusion and rate
// products register, then the phase update into the output register, to become the result beat.
// Throughput one beat per clock while the output is not held; the phase state updates once per beat, so the only loop
// is the single-stage state update. Back pressure holds every stage in place.
// Reset (arst_n low) clears all valids, the phase state and the flight mode to idle,
// and loads the configuration registers with their defaults.

module flight_phase_detector_top #(
	parameter int ALT_BITS   = fpd_pkg::ALT_BITS_DEF,
	parameter int COUNT_BITS = fpd_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// cfg_wdata holds the widest register (altitude or alpha)
	input  logic                             cfg_wen,
	input  logic [fpd_pkg::IDX_W-1:0]        cfg_idx,
	input  logic [((ALT_BITS > 17) ? ALT_BITS : 17)-1:0] cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// baro_alt_cm, baro_ok, gps_alt_cm, gps_ok, dt_ms, target_dist_m, zero pad
	input  logic [((2*ALT_BITS+42+7)/8)*8-1:0] s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// fused_alt_cm, fused_ok, flight_mode, apogee_ticks, apogee_flag, ground_ticks, zero pad
	output logic [((ALT_BITS+36+7)/8)*8-1:0] m_tdata
);
	import fpd_pkg::*;

	localparam int CFG_W  = (ALT_BITS > 17) ? ALT_BITS : 17;
	localparam int IN_W   = ((2*ALT_BITS+42+7)/8)*8;
	localparam int OUT_W  = ((ALT_BITS+36+7)/8)*8;
	localparam int PROD_W = RATE_W + DT_W;
	localparam int DIFF_W = ALT_BITS + 1;
	localparam int CMP_W  = (ALT_BITS + 12 > PROD_W + 2) ? ALT_BITS + 12 : PROD_W + 2;
	localparam int CNT_W  = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;
	localparam int OUT_PAD = OUT_W - (ALT_BITS + 36);

	// configuration
	logic        [ALPHA_W-1:0]  alpha_q;
	logic signed [ALT_BITS-1:0] apo_floor_q;
	logic signed [ALT_BITS-1:0] gnd_ceil_q;
	logic        [RATE_W-1:0]   desc_rate_q;
	logic        [RATE_W-1:0]   still_band_q;
	logic        [RATE_W-1:0]   apo_limit_q;
	logic        [RATE_W-1:0]   gnd_limit_q;
	logic        [RATE_W-1:0]   spiral_rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= ALPHA_RST;
			apo_floor_q  <= {1'b0, {(ALT_BITS-1){1'b1}}};
			gnd_ceil_q   <= {1'b1, {(ALT_BITS-1){1'b0}}};
			desc_rate_q  <= DESC_RATE_RST;
			still_band_q <= STILL_BAND_RST;
			apo_limit_q  <= APO_LIMIT_RST;
			gnd_limit_q  <= GND_LIMIT_RST;
			spiral_rad_q <= SPIRAL_RAD_RST;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_idx))
				REG_ALPHA:      alpha_q      <= cfg_wdata[ALPHA_W-1:0];
				REG_APO_FLOOR:  apo_floor_q  <= cfg_wdata[ALT_BITS-1:0];
				REG_GND_CEIL:   gnd_ceil_q   <= cfg_wdata[ALT_BITS-1:0];
				REG_DESC_RATE:  desc_rate_q  <= cfg_wdata[RATE_W-1:0];
				REG_STILL_BAND: still_band_q <= cfg_wdata[RATE_W-1:0];
				REG_APO_LIMIT:  apo_limit_q  <= cfg_wdata[RATE_W-1:0];
				REG_GND_LIMIT:  gnd_limit_q  <= cfg_wdata[RATE_W-1:0];
				REG_SPIRAL_RAD: spiral_rad_q <= cfg_wdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control: each stage moves when the next one is empty or moving
	logic v_s1, v_s2;
	logic rdy_out, rdy_s2;

	assign rdy_out  = !m_tvalid || m_tready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign s_tready = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (rdy_s2)   v_s2 <= v_s1;
			if (rdy_out)  m_tvalid <= v_s2;
		end
	end

	// stage 1: input register
	logic signed [ALT_BITS-1:0] baro_s1, gps_s1;
	logic                       baro_ok_s1, gps_ok_s1;
	logic        [DT_W-1:0]     dt_s1;
	logic        [DIST_W-1:0]   dist_s1;

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			baro_s1    <= s_tdata[ALT_BITS-1:0];
			baro_ok_s1 <= s_tdata[ALT_BITS];
			gps_s1     <= s_tdata[2*ALT_BITS:ALT_BITS+1];
			gps_ok_s1  <= s_tdata[2*ALT_BITS+1];
			dt_s1      <= s_tdata[2*ALT_BITS+2 +: DT_W];
			dist_s1    <= s_tdata[2*ALT_BITS+2+DT_W +: DIST_W];
		end
	end

	logic signed [ALT_BITS-1:0] fused_c;
	logic                       fused_ok_c;

	fpd_fuse #(
		.ALT_BITS (ALT_BITS)
	) u_fuse (
		.baro_alt_cm  (baro_s1),
		.baro_ok      (baro_ok_s1),
		.gps_alt_cm   (gps_s1),
		.gps_ok       (gps_ok_s1),
		.alpha_q16    (alpha_q),
		.fused_alt_cm (fused_c),
		.fused_ok     (fused_ok_c)
	);

	// stage 2: fused altitude and the dt-scaled thresholds
	logic signed [ALT_BITS-1:0] fused_s2;
	logic                       fused_ok_s2, dt_nz_s2, near_s2;
	logic        [PROD_W-1:0]   desc_s2, band_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			fused_s2    <= fused_c;
			fused_ok_s2 <= fused_ok_c;
			dt_nz_s2    <= (dt_s1 != '0);
			near_s2     <= (dist_s1 < DIST_W'(spiral_rad_q));
			desc_s2     <= PROD_W'(desc_rate_q) * PROD_W'(dt_s1);
			band_s2     <= PROD_W'(still_band_q) * PROD_W'(dt_s1);
		end
	end

	// phase state
	logic signed [ALT_BITS-1:0]   last_alt_q;
	logic                         last_ok_q;
	logic        [COUNT_BITS-1:0] apo_cnt_q, gnd_cnt_q;
	logic                         apo_seen_q;
	mode_t                        mode_q;

	logic                         judged;
	logic signed [DIFF_W-1:0]     d;
	logic signed [CMP_W-1:0]      d_w, dv, desc_w, band_w;
	logic                         apo_hit, still_hit;
	logic        [COUNT_BITS-1:0] apo_nxt, gnd_nxt;
	logic                         seen_nxt;
	mode_t                        mode_nxt;

	assign judged = fused_ok_s2 && last_ok_q && dt_nz_s2;
	assign d      = DIFF_W'(fused_s2) - DIFF_W'(last_alt_q);
	assign d_w    = CMP_W'(d);
	// d * 1000 as 1024 - 16 - 8
	assign dv     = (d_w <<< 10) - (d_w <<< 4) - (d_w <<< 3);
	assign desc_w = signed'(CMP_W'(desc_s2));
	assign band_w = signed'(CMP_W'(band_s2));

	assign apo_hit   = judged && (dv <= -desc_w) && (fused_s2 > apo_floor_q);
	assign still_hit = judged && (dv < band_w) && (dv > -band_w) && (fused_s2 < gnd_ceil_q);

	always_comb begin
		apo_nxt = apo_cnt_q;
		if (apo_hit && apo_cnt_q != '1) apo_nxt = apo_cnt_q + 1'b1;
		seen_nxt = apo_seen_q || (CNT_W'(apo_nxt) >= CNT_W'(apo_limit_q));
		gnd_nxt  = gnd_cnt_q;
		mode_nxt = mode_q;
		if (seen_nxt) begin
			mode_nxt = near_s2 ? MODE_SPIRAL : MODE_SEEK;
			if (still_hit && gnd_cnt_q != '1) gnd_nxt = gnd_cnt_q + 1'b1;
			if (CNT_W'(gnd_nxt) >= CNT_W'(gnd_limit_q)) mode_nxt = MODE_GROUND;
		end
	end

	logic adv_s2;
	assign adv_s2 = v_s2 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_alt_q <= '0;
			last_ok_q  <= 1'b0;
			apo_cnt_q  <= '0;
			gnd_cnt_q  <= '0;
			apo_seen_q <= 1'b0;
			mode_q     <= MODE_IDLE;
		end else if (adv_s2) begin
			if (fused_ok_s2) last_alt_q <= fused_s2;
			last_ok_q  <= fused_ok_s2;
			apo_cnt_q  <= apo_nxt;
			gnd_cnt_q  <= gnd_nxt;
			apo_seen_q <= seen_nxt;
			mode_q     <= mode_nxt;
		end
	end

	// output register
	logic [CNT_W-1:0] apo_ext, gnd_ext;
	assign apo_ext = CNT_W'(apo_nxt);
	assign gnd_ext = CNT_W'(gnd_nxt);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			m_tdata <= {{OUT_PAD{1'b0}}, gnd_ext[TICK_W-1:0], seen_nxt,
				apo_ext[TICK_W-1:0], mode_nxt, fused_ok_s2, fused_s2};
		end
	end

endmodule

>>> bench/fpd_phase_checker.sv
// Checker for the flight phase detector: watches the config port and both stream channels,
// predicts one report per accepted tick beat and compares it field by field.
// Depends on fpd_pkg for the register indexes, the mode encoding and the reset defaults.

module fpd_phase_checker
	import fpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [IDX_W-1:0]      cfg_idx,
	input  logic [ALT_BITS_DEF-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// baro_alt_cm, baro_ok, gps_alt_cm, gps_ok, dt_ms, target_dist_m, zero pad
	input  logic [((2*ALT_BITS_DEF+42+7)/8)*8-1:0] s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// fused_alt_cm, fused_ok, flight_mode, apogee_ticks, apogee_flag, ground_ticks, zero pad
	input  logic [((ALT_BITS_DEF+36+7)/8)*8-1:0] m_tdata,
	output int                    fail_count,
	output int                    outstanding
);

	localparam int ALT_W = ALT_BITS_DEF;
	localparam int IN_W  = ((2*ALT_W+42+7)/8)*8;
	localparam int OUT_W = ((ALT_W+36+7)/8)*8;
	localparam longint CNT_MAX = (longint'(1) << COUNT_BITS_DEF) - 1;
	localparam longint ALT_MAX = (longint'(1) << (ALT_W-1)) - 1;
	localparam longint ALT_MIN = -ALT_MAX - 1;
	localparam longint Q16_ONE = longint'(ALPHA_ONE);

	// settings as the block holds them
	longint w_baro, floor_cm, ceil_cm, sink_rate, still_rate, apo_need, gnd_need, spiral_m;

	// detector state
	longint prev_alt;
	bit     prev_valid;
	longint apo_cnt, gnd_cnt;
	bit     apo_latched;
	mode_t  mode;

	logic [OUT_W-1:0] report_queue[$];

	// Advance the detector by one tick beat and return the report it produces.
	function automatic logic [OUT_W-1:0] next_report(logic [IN_W-1:0] beat);
		longint baro, gps, dt, dist_m, wt, fused, dv, sink_lim, still_lim;
		bit baro_ok, gps_ok, alt_ok, judged;
		baro    = longint'($signed(beat[23:0]));
		baro_ok = beat[24];
		gps     = longint'($signed(beat[48:25]));
		gps_ok  = beat[49];
		dt      = longint'(beat[65:50]);
		dist_m  = longint'(beat[89:66]);
		wt      = (w_baro > Q16_ONE) ? Q16_ONE : w_baro;
		alt_ok  = baro_ok || gps_ok;
		fused   = 0;
		if (baro_ok && gps_ok) begin
			fused = (baro * wt + gps * (Q16_ONE - wt)) >>> 16;
		end else if (baro_ok) begin
			fused = baro;
		end else if (gps_ok) begin
			fused = gps;
		end

		// speed compared by cross-multiplying with dt, no division
		judged    = alt_ok && prev_valid && dt != 0;
		dv        = (fused - prev_alt) * 1000;
		sink_lim  = sink_rate * dt;
		still_lim = still_rate * dt;

		if (judged && dv <= -sink_lim && fused > floor_cm) begin
			apo_cnt = (apo_cnt >= CNT_MAX) ? CNT_MAX : apo_cnt + 1;
		end
		if (apo_cnt >= apo_need) begin
			apo_latched = 1'b1;
		end
		if (apo_latched) begin
			mode = (dist_m < spiral_m) ? MODE_SPIRAL : MODE_SEEK;
			if (judged && dv < still_lim && dv > -still_lim && fused < ceil_cm) begin
				gnd_cnt = (gnd_cnt >= CNT_MAX) ? CNT_MAX : gnd_cnt + 1;
			end
			if (gnd_cnt >= gnd_need) begin
				mode = MODE_GROUND;
			end
		end

		if (alt_ok) begin
			prev_alt = fused;
		end
		prev_valid = alt_ok;

		return {{(OUT_W-60){1'b0}}, 16'(gnd_cnt), apo_latched, 16'(apo_cnt), mode, alt_ok,
			24'(fused)};
	endfunction

	function automatic int field_ok(string name, logic signed [63:0] want,
		logic signed [63:0] got);
		if (want === got) begin
			return 0;
		end
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0] want;
		int bad;
		if (!arst_n) begin
			w_baro      = longint'(ALPHA_RST);
			floor_cm    = ALT_MAX;
			ceil_cm     = ALT_MIN;
			sink_rate   = longint'(DESC_RATE_RST);
			still_rate  = longint'(STILL_BAND_RST);
			apo_need    = longint'(APO_LIMIT_RST);
			gnd_need    = longint'(GND_LIMIT_RST);
			spiral_m    = longint'(SPIRAL_RAD_RST);
			prev_alt    = 0;
			prev_valid  = 1'b0;
			apo_cnt     = 0;
			gnd_cnt     = 0;
			apo_latched = 1'b0;
			mode        = MODE_IDLE;
			report_queue.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (cfg_wen) begin
				case (reg_idx_t'(cfg_idx))
					REG_ALPHA:      w_baro     = longint'(cfg_wdata[ALPHA_W-1:0]);
					REG_APO_FLOOR:  floor_cm   = longint'($signed(cfg_wdata[ALT_W-1:0]));
					REG_GND_CEIL:   ceil_cm    = longint'($signed(cfg_wdata[ALT_W-1:0]));
					REG_DESC_RATE:  sink_rate  = longint'(cfg_wdata[RATE_W-1:0]);
					REG_STILL_BAND: still_rate = longint'(cfg_wdata[RATE_W-1:0]);
					REG_APO_LIMIT:  apo_need   = longint'(cfg_wdata[RATE_W-1:0]);
					REG_GND_LIMIT:  gnd_need   = longint'(cfg_wdata[RATE_W-1:0]);
					REG_SPIRAL_RAD: spiral_m   = longint'(cfg_wdata[RATE_W-1:0]);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				report_queue.push_back(next_report(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (report_queue.size() == 0) begin
					$error("report beat %h arrived with no tick pending", m_tdata);
					bad = 1;
				end else begin
					want = report_queue.pop_front();
					bad = field_ok("fused_alt_cm", $signed(want[23:0]), $signed(m_tdata[23:0]))
						+ field_ok("fused_ok", want[24], m_tdata[24])
						+ field_ok("flight_mode", want[26:25], m_tdata[26:25])
						+ field_ok("apogee_ticks", want[42:27], m_tdata[42:27])
						+ field_ok("apogee_flag", want[43], m_tdata[43])
						+ field_ok("ground_ticks", want[59:44], m_tdata[59:44]);
				end
			end
			fail_count  <= fail_count + bad;
			outstanding <= report_queue.size();
		end
	end

endmodule

>>> bench/tb_top.sv
// Testbench top for flight_phase_detector_top: clock, reset, config writes and tick stimulus.
// Directed ticks, then descent profiles under several settings and a level-flight burst.
// Depends on fpd_pkg, the RTL top and fpd_phase_checker, which does all the checking.

module tb_top;
	import fpd_pkg::*;

	localparam int ALT_W       = ALT_BITS_DEF;
	localparam int IN_W        = ((2*ALT_W+42+7)/8)*8;
	localparam int OUT_W       = ((ALT_W+36+7)/8)*8;
	localparam int CFG_W       = (ALT_W > 17) ? ALT_W : 17;
	localparam int LIMIT       = 2_000_000;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_TICKS = 225;
	localparam int LEVEL_TICKS = 80;

	logic             clk;
	logic             arst_n;
	logic             cfg_wen;
	logic [IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	int               fail_count;
	int               outstanding;

	bit no_idle;
	bit hold_off_pending;
	logic [CFG_W-1:0] cfg_plan [0:(1<<IDX_W)-1];

	// descent profile driving the well-formed ticks
	int traj_alt, traj_ground, traj_speed, traj_dist;

	flight_phase_detector_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	fpd_phase_checker i_phase_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [IN_W-1:0] make_tick(int baro, bit baro_ok, int gps, bit gps_ok,
		int dt, int dist_m);
		return {{(IN_W-90){1'b0}}, 24'(dist_m), 16'(dt), gps_ok, 24'(gps), baro_ok, 24'(baro)};
	endfunction

	task automatic start_flight();
		traj_ground = int'($urandom_range(0, 200000)) - 100000;
		traj_alt    = traj_ground + int'($urandom_range(2000, 40000));
		traj_speed  = $urandom_range(200, 3000);
		traj_dist   = $urandom_range(0, 20000);
	endtask

	// One tick along the descent profile; some beats are plain noise.
	function automatic logic [IN_W-1:0] next_flight_tick();
		logic [IN_W-1:0] beat;
		int dt, r, j_baro, j_gps;
		if ($urandom_range(0, 9) == 0) begin
			beat = {$urandom, $urandom, $urandom};
			beat[IN_W-1:90] = '0;
			return beat;
		end
		r = $urandom_range(0, 39);
		if (r < 2) begin
			dt = 0;
		end else if (r == 2) begin
			dt = $urandom_range(0, 65535);
		end else begin
			dt = $urandom_range(5, 200);
		end
		if ($urandom_range(0, 49) == 0) begin
			traj_speed = int'($urandom_range(0, 3300)) - 300;
		end
		if (traj_alt > traj_ground) begin
			traj_alt -= traj_speed * dt / 1000;
			if (traj_alt < traj_ground) traj_alt = traj_ground;
			if (traj_alt > 4000000) traj_alt = 4000000;
		end
		j_baro = ($urandom_range(0, 3) != 0) ? 0 : int'($urandom_range(0, 6)) - 3;
		j_gps  = ($urandom_range(0, 3) != 0) ? 0 : int'($urandom_range(0, 6)) - 3;
		if ($urandom_range(0, 29) == 0) begin
			traj_dist = $urandom_range(0, 24'hFFFFFF);
		end else begin
			traj_dist -= int'($urandom_range(0, 60));
			if (traj_dist < 0) traj_dist = 0;
		end
		return make_tick(traj_alt + j_baro, $urandom_range(0, 15) != 0,
			traj_alt + j_gps, $urandom_range(0, 7) != 0, dt, traj_dist);
	endfunction

	function automatic logic [CFG_W-1:0] pick_rate(int typical);
		case ($urandom_range(0, 15))
			0: return '0;
			1: return CFG_W'(16'hFFFF);
			2: return CFG_W'($urandom);       // junk above the register width
			default: return CFG_W'($urandom_range(0, typical));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_alt(int lo, int span);
		case ($urandom_range(0, 7))
			0: return CFG_W'(24'h800000);
			1: return CFG_W'(24'h7FFFFF);
			default: return CFG_W'(lo + int'($urandom_range(0, span)));
		endcase
	endfunction

	task automatic plan_random();
		case ($urandom_range(0, 5))
			0: cfg_plan[REG_ALPHA] = '0;
			1: cfg_plan[REG_ALPHA] = CFG_W'(ALPHA_ONE);
			2: cfg_plan[REG_ALPHA] = CFG_W'($urandom);
			default: cfg_plan[REG_ALPHA] = CFG_W'($urandom_range(0, 65536));
		endcase
		cfg_plan[REG_APO_FLOOR]  = pick_alt(traj_ground, traj_alt - traj_ground);
		cfg_plan[REG_GND_CEIL]   = pick_alt(traj_ground, 2000);
		cfg_plan[REG_DESC_RATE]  = pick_rate(600);
		cfg_plan[REG_STILL_BAND] = pick_rate(80);
		cfg_plan[REG_APO_LIMIT]  = pick_rate(30);
		cfg_plan[REG_GND_LIMIT]  = pick_rate(30);
		cfg_plan[REG_SPIRAL_RAD] = pick_rate(3000);
	endtask

	// every register at its lowest or its highest encoding
	task automatic plan_uniform(bit top);
		cfg_plan[REG_ALPHA]      = top ? '1 : '0;
		cfg_plan[REG_APO_FLOOR]  = top ? CFG_W'(24'h7FFFFF) : CFG_W'(24'h800000);
		cfg_plan[REG_GND_CEIL]   = top ? CFG_W'(24'h7FFFFF) : CFG_W'(24'h800000);
		cfg_plan[REG_DESC_RATE]  = top ? '1 : '0;
		cfg_plan[REG_STILL_BAND] = top ? '1 : '0;
		cfg_plan[REG_APO_LIMIT]  = top ? '1 : '0;
		cfg_plan[REG_GND_LIMIT]  = top ? '1 : '0;
		cfg_plan[REG_SPIRAL_RAD] = top ? '1 : '0;
	endtask

	task automatic write_settings();
		reg_idx_t r;
		r = r.first();
		do begin
			cfg_wen   <= 1'b1;
			cfg_idx   <= r;
			cfg_wdata <= cfg_plan[r];
			@(posedge clk);
			r = r.next();
		end while (r != r.first());
		cfg_wen <= 1'b0;
	endtask

	// offer one beat after a random gap; returns at the edge that takes it
	task automatic send_tick(logic [IN_W-1:0] beat);
		int gap;
		gap = no_idle ? 0 : idle_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side: ready runs broken by stalls, one long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : idle_len();
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	initial begin
		int cycles;
		for (cycles = 0; cycles < LIMIT; cycles++) @(posedge clk);
		$display("[flight_phase_detector_top] ERROR");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		cfg_wen          = 1'b0;
		cfg_idx          = REG_ALPHA;
		cfg_wdata        = '0;
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		no_idle          = 1'b0;
		hold_off_pending = 1'b0;
		cfg_plan[REG_ALPHA]      = CFG_W'(ALPHA_RST);
		cfg_plan[REG_APO_FLOOR]  = CFG_W'(24'h7FFFFF);
		cfg_plan[REG_GND_CEIL]   = CFG_W'(24'h800000);
		cfg_plan[REG_DESC_RATE]  = CFG_W'(DESC_RATE_RST);
		cfg_plan[REG_STILL_BAND] = CFG_W'(STILL_BAND_RST);
		cfg_plan[REG_APO_LIMIT]  = CFG_W'(APO_LIMIT_RST);
		cfg_plan[REG_GND_LIMIT]  = CFG_W'(GND_LIMIT_RST);
		cfg_plan[REG_SPIRAL_RAD] = CFG_W'(SPIRAL_RAD_RST);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks under reset settings: field extremes, fusion cases, skipped judging
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		send_tick(make_tick(8388607, 1, -8388608, 0, 1000, 0));
		send_tick(make_tick(8388607, 1, 8388607, 1, 65535, 16777215));
		send_tick(make_tick(-8388608, 1, -8388608, 1, 1, 16777215));
		send_tick(make_tick(-8388608, 1, 8388607, 1, 100, 5));
		send_tick(make_tick(-8388608, 0, 8388607, 1, 65535, 9));
		send_tick(make_tick(8388607, 0, 8388607, 0, 50, 10));
		send_tick(make_tick(1000, 1, 999, 1, 100, 11));
		send_tick(make_tick(500, 1, 500, 1, 0, 100));
		send_tick(make_tick(-1, 1, -2, 1, 10, 100));
		send_tick(make_tick(1, 1, 0, 1, 10, 100));
		send_tick(make_tick(-1, 1, 0, 1, 10, 100));
		// weight of exactly one, then above one (saturates), then zero
		drain_results();
		cfg_plan[REG_ALPHA] = CFG_W'(ALPHA_ONE);
		write_settings();
		send_tick(make_tick(100, 1, -100, 1, 20, 3));
		send_tick(make_tick(-8388608, 1, 8388607, 1, 20, 3));
		drain_results();
		cfg_plan[REG_ALPHA] = '1;
		write_settings();
		send_tick(make_tick(100, 1, -100, 1, 20, 3));
		send_tick(make_tick(8388607, 1, -8388608, 1, 20, 3));
		drain_results();
		cfg_plan[REG_ALPHA] = '0;
		write_settings();
		send_tick(make_tick(100, 1, -100, 1, 20, 3));
		send_tick(make_tick(-7, 1, 8388607, 1, 20, 3));

		// first descent: apogee gets declared part way through, under a long result hold-off
		drain_results();
		start_flight();
		cfg_plan[REG_ALPHA]      = CFG_W'($urandom_range(0, 65536));
		cfg_plan[REG_APO_FLOOR]  = CFG_W'(traj_ground);
		cfg_plan[REG_GND_CEIL]   = CFG_W'(traj_ground + 1000);
		cfg_plan[REG_DESC_RATE]  = CFG_W'(120);
		cfg_plan[REG_STILL_BAND] = CFG_W'(30);
		cfg_plan[REG_APO_LIMIT]  = CFG_W'(25);
		cfg_plan[REG_GND_LIMIT]  = CFG_W'(30);
		cfg_plan[REG_SPIRAL_RAD] = CFG_W'(2000);
		write_settings();
		hold_off_pending = 1'b1;
		repeat (PHASE_TICKS) send_tick(next_flight_tick());

		for (int p = 0; p < 5; p++) begin
			drain_results();
			start_flight();
			if (p == 0) begin
				plan_uniform(1'b0);
			end else if (p == 1) begin
				plan_uniform(1'b1);
			end else begin
				plan_random();
			end
			write_settings();
			repeat (PHASE_TICKS) send_tick(next_flight_tick());
		end

		// level flight with zero sink rate: every tick counts, apogee then grounded
		drain_results();
		cfg_plan[REG_ALPHA]      = CFG_W'($urandom_range(0, 65536));
		cfg_plan[REG_APO_FLOOR]  = CFG_W'(24'h800000);
		cfg_plan[REG_GND_CEIL]   = CFG_W'(24'h7FFFFF);
		cfg_plan[REG_DESC_RATE]  = '0;
		cfg_plan[REG_STILL_BAND] = CFG_W'(1);
		cfg_plan[REG_APO_LIMIT]  = CFG_W'(20);
		cfg_plan[REG_GND_LIMIT]  = CFG_W'(40);
		cfg_plan[REG_SPIRAL_RAD] = CFG_W'($urandom_range(0, 4000));
		write_settings();
		no_idle = 1'b1;
		for (int i = 0; i < LEVEL_TICKS; i++) begin
			send_tick(make_tick(1000, 1, 1000, 1, 1, $urandom_range(0, 4000)));
		end
		no_idle = 1'b0;

		drain_results();
		start_flight();
		plan_random();
		write_settings();
		repeat (100) send_tick(next_flight_tick());

		drain_results();
		if (fail_count == 0 && outstanding == 0) begin
			$display("[flight_phase_detector_top] OK");
		end else begin
			$display("[flight_phase_detector_top] ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/fpd_pkg.sv
rtl/fpd_fuse.sv
rtl/flight_phase_detector_top.sv
bench/fpd_phase_checker.sv
bench/tb_top.sv
